[hdl/tcw_pkg.sv]
`default_nettype none
package tcw_pkg;

	localparam logic [2:0] OP_PUT        = 3'd0;
	localparam logic [2:0] OP_CLEAR      = 3'd1;
	localparam logic [2:0] OP_SET_COLORS = 3'd2;
	localparam logic [2:0] OP_SET_FORE   = 3'd3;
	localparam logic [2:0] OP_RESTORE    = 3'd4;
	localparam logic [2:0] OP_SCROLL     = 3'd5;
	localparam logic [2:0] OP_READ       = 3'd6;

	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] BACK_MASK  = 8'hF0;
	localparam logic [7:0] FORE_MASK  = 8'h0F;

	localparam int CELL_W = 16;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  char_code;
		logic [3:0]  fore_color;
		logic [3:0]  back_color;
		logic [7:0]  scroll_rows;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic [7:0]  current_attribute;
	} rsp_t;

	// walker command: start a pass, with or without the upward copy
	typedef struct packed {
		logic start;
		logic copy;
	} wk_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} wk_sts_t;

endpackage
`default_nettype wire

[hdl/text_console_writer.sv]
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_t: op, char, colors, scroll rows, cell index
// rsp     | out       | rsp_valid/rsp_ready | rsp_t: cursor, read cell, current attribute
// cfg     | in        | cfg_we              | cfg_wdata: default attribute
//
// Put char, color and restore ops: a new request is taken every cycle
// while rsp drains. Read cell: the registered cell RAM read returns in ST_READ, then ST_RESP loads it.
// Clear and full-screen scroll run the walker's fill pass; other scrolls and scroll-on-wrap
// run its copy pass, a drain step, then the fill pass, one cell per cycle through one write port.
// After reset the walker clears the store while req_ready is held low.
// A stalled rsp holds at most one finished result; the next request is still taken.
`default_nettype none
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int NW    = $clog2(ROWS + 1);
	localparam int PW    = $clog2(TAB_STOP + 1);
	localparam int TSW   = CW + PW;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0]    st_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] ph_q;     // column mod TAB_STOP
	logic [7:0]    attr_q;
	logic [7:0]    prev_q;
	logic [7:0]    rc_q;
	logic [7:0]    ra_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [CW-1:0] nx_col;
	logic [RW-1:0] nx_row;
	logic [PW-1:0] nx_ph;
	logic [7:0]    nx_attr;
	logic [7:0]    nx_prev;
	logic          new_line;
	logic          go_read;
	logic          done_now;
	logic          acc;
	logic          slot_free;
	logic          load_out;

	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     nx_addr;
	logic              col_last;
	logic              row_last;
	logic [TSW-1:0]    tab_sum;
	logic              tab_wrap;
	logic [NW-1:0]     scroll_n;
	logic [AW-1:0]     scroll_shift;
	logic [AW-1:0]     scroll_base;
	logic              idx_ok;

	logic              d_wr_en;
	logic [AW-1:0]     d_wr_addr;
	logic [CELL_W-1:0] d_wr_data;
	logic              d_rd_en;
	logic [AW-1:0]     d_rd_addr;

	wk_ctl_t           wk_ctl;
	wk_sts_t           wk_sts;
	logic [AW-1:0]     wk_shift;
	logic [AW-1:0]     wk_base;
	logic              wk_rd_en;
	logic [AW-1:0]     wk_rd_addr;
	logic              wk_wr_en;
	logic [AW-1:0]     wk_wr_addr;
	logic [CELL_W-1:0] wk_wr_data;

	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic [CELL_W-1:0] ram_rd_data;
	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	logic [CELL_W-1:0] ram_wr_data;

	// There is no default attribute register: the attribute resets to ATTR_RESET, and a cfg
	// write never reaches the cursor, attribute or store, so cfg_we/cfg_wdata end here.

	assign acc       = req_valid && req_ready;
	assign req_ready = (st_q == ST_IDLE);
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign cur_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign nx_addr  = AW'(nx_row) * AW'(COLUMNS) + AW'(nx_col);
	assign col_last = (col_q == CW'(COLUMNS - 1));
	assign row_last = (row_q == RW'(ROWS - 1));

	assign tab_sum  = TSW'(col_q) + TSW'(PW'(TAB_STOP) - ph_q);
	assign tab_wrap = (tab_sum >= TSW'(COLUMNS));

	assign scroll_n     = (req.scroll_rows > 8'(ROWS)) ? NW'(ROWS) : NW'(req.scroll_rows);
	assign scroll_shift = AW'(scroll_n) * AW'(COLUMNS);
	assign scroll_base  = AW'(NW'(ROWS) - scroll_n) * AW'(COLUMNS);
	assign idx_ok       = (int'(req.cell_index) < CELLS);

	always_comb begin
		nx_col    = col_q;
		nx_row    = row_q;
		nx_ph     = ph_q;
		nx_attr   = attr_q;
		nx_prev   = prev_q;
		new_line  = 1'b0;
		go_read   = 1'b0;
		d_wr_en   = 1'b0;
		d_wr_addr = cur_addr;
		d_wr_data = {8'h00, attr_q};
		d_rd_en   = 1'b0;
		d_rd_addr = AW'(req.cell_index);
		wk_ctl    = '0;
		wk_shift  = AW'(COLUMNS);
		wk_base   = AW'(CELLS - COLUMNS);
		if (acc) begin
			case (req.op)
				OP_PUT: begin
					case (req.char_code)
						CH_NL: begin
							new_line = 1'b1;
						end
						CH_CR: begin
							nx_col = '0;
							nx_ph  = '0;
						end
						CH_BS: begin
							if (col_q != '0) begin
								d_wr_en   = 1'b1;
								d_wr_addr = cur_addr - AW'(1);
								nx_col    = col_q - CW'(1);
								nx_ph     = (ph_q == '0) ? PW'(TAB_STOP - 1) : ph_q - PW'(1);
							end
						end
						CH_HT: begin
							if (tab_wrap) begin
								new_line = 1'b1;
							end else begin
								nx_col = CW'(tab_sum);
								nx_ph  = '0;
							end
						end
						default: begin
							d_wr_en   = 1'b1;
							d_wr_data = {req.char_code, attr_q};
							if (col_last) begin
								new_line = 1'b1;
							end else begin
								nx_col = col_q + CW'(1);
								nx_ph  = (ph_q == PW'(TAB_STOP - 1)) ? '0 : ph_q + PW'(1);
							end
						end
					endcase
					if (new_line) begin
						nx_col = '0;
						nx_ph  = '0;
						if (row_last) begin
							// bottom row: scroll one row, cursor stays on the last row
							wk_ctl.start = 1'b1;
							wk_ctl.copy  = 1'b1;
						end else begin
							nx_row = row_q + RW'(1);
						end
					end
				end
				OP_CLEAR: begin
					wk_ctl.start = 1'b1;
					wk_base      = '0;
					nx_col       = '0;
					nx_row       = '0;
					nx_ph        = '0;
				end
				OP_SET_COLORS: begin
					nx_prev = attr_q;
					nx_attr = {req.back_color, req.fore_color};
				end
				OP_SET_FORE: begin
					nx_prev = attr_q;
					nx_attr = (attr_q & BACK_MASK) | ({4'h0, req.fore_color} & FORE_MASK);
				end
				OP_RESTORE: begin
					nx_attr = prev_q;
				end
				OP_SCROLL: begin
					if (scroll_n != '0) begin
						wk_ctl.start = 1'b1;
						wk_ctl.copy  = 1'b1;
						wk_shift     = scroll_shift;
						wk_base      = scroll_base;
						nx_row       = RW'(NW'(ROWS) - scroll_n);
						nx_col       = '0;
						nx_ph        = '0;
					end
				end
				OP_READ: begin
					if (idx_ok) begin
						d_rd_en = 1'b1;
						go_read = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done_now = acc && !wk_ctl.start && !go_read;
	assign load_out = ((st_q == ST_IDLE) && done_now && slot_free)
		|| ((st_q == ST_RESP) && slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			ph_q        <= '0;
			attr_q      <= ATTR_RESET;
			prev_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			col_q  <= nx_col;
			row_q  <= nx_row;
			ph_q   <= nx_ph;
			attr_q <= nx_attr;
			prev_q <= nx_prev;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				ST_INIT: begin
					if (wk_sts.done) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (wk_ctl.start) begin
							st_q <= ST_WALK;
						end else if (go_read) begin
							st_q <= ST_READ;
						end else if (!slot_free) begin
							st_q <= ST_RESP;
						end
					end
				end
				ST_WALK: begin
					if (wk_sts.done) begin
						st_q <= ST_RESP;
					end
				end
				ST_READ: begin
					st_q <= ST_RESP;
				end
				ST_RESP: begin
					if (slot_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// only a read fills the cell fields; every other transaction reports zero
		if (st_q == ST_READ) begin
			rc_q <= ram_rd_data[15:8];
			ra_q <= ram_rd_data[7:0];
		end else if (acc) begin
			rc_q <= 8'h00;
			ra_q <= 8'h00;
		end
		if (load_out) begin
			rsp_q.cursor_position   <= 11'(nx_addr);
			rsp_q.cell_char         <= (st_q == ST_RESP) ? rc_q : 8'h00;
			rsp_q.cell_attr         <= (st_q == ST_RESP) ? ra_q : 8'h00;
			rsp_q.current_attribute <= nx_attr;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// walker owns the RAM ports while a pass runs; requests only arrive when it is idle
	assign ram_rd_en   = wk_sts.busy ? wk_rd_en   : d_rd_en;
	assign ram_rd_addr = wk_sts.busy ? wk_rd_addr : d_rd_addr;
	assign ram_wr_en   = wk_sts.busy ? wk_wr_en   : d_wr_en;
	assign ram_wr_addr = wk_sts.busy ? wk_wr_addr : d_wr_addr;
	assign ram_wr_data = wk_sts.busy ? wk_wr_data : d_wr_data;

	tcw_walker #(
		.CELLS (CELLS),
		.AW    (AW)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (wk_ctl),
		.shift     (wk_shift),
		.base      (wk_base),
		.fill_attr (attr_q),
		.rd_data   (ram_rd_data),
		.rd_en     (wk_rd_en),
		.rd_addr   (wk_rd_addr),
		.wr_en     (wk_wr_en),
		.wr_addr   (wk_wr_addr),
		.wr_data   (wk_wr_data),
		.sts       (wk_sts)
	);

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_cell_ram (
		.clk     (clk),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

endmodule
`default_nettype wire

[hdl/tcw_cell_ram.sv]
`default_nettype none
module tcw_cell_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [CELL_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [CELL_W-1:0] wr_data
);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[hdl/tcw_walker.sv]
`default_nettype none
module tcw_walker
	import tcw_pkg::*;
#(
	parameter int CELLS = 2000,
	parameter int AW    = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wk_ctl_t           ctl,
	input  wire logic [AW-1:0]     shift,
	input  wire logic [AW-1:0]     base,
	input  wire logic [7:0]        fill_attr,
	input  wire logic [CELL_W-1:0] rd_data,
	output logic                   rd_en,
	output logic      [AW-1:0]     rd_addr,
	output logic                   wr_en,
	output logic      [AW-1:0]     wr_addr,
	output logic      [CELL_W-1:0] wr_data,
	output wk_sts_t                sts
);

	localparam logic [1:0] W_IDLE  = 2'd0;
	localparam logic [1:0] W_COPY  = 2'd1;
	localparam logic [1:0] W_DRAIN = 2'd2;
	localparam logic [1:0] W_FILL  = 2'd3;

	localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

	logic [1:0]    ws_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] shift_q;
	logic [AW-1:0] base_q;
	logic          cpv_s1;
	logic [AW-1:0] dst_s1;

	// reset enters the fill pass directly: the power-on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= W_FILL;
			ptr_q  <= '0;
			cpv_s1 <= 1'b0;
		end else begin
			cpv_s1 <= (ws_q == W_COPY);
			case (ws_q)
				W_IDLE: begin
					if (ctl.start) begin
						if (ctl.copy && base != '0) begin
							ws_q  <= W_COPY;
							ptr_q <= '0;
						end else begin
							ws_q  <= W_FILL;
							ptr_q <= base;
						end
					end
				end
				W_COPY: begin
					if (ptr_q == base_q - AW'(1)) begin
						ws_q <= W_DRAIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				W_DRAIN: begin
					ws_q  <= W_FILL;
					ptr_q <= base_q;
				end
				W_FILL: begin
					if (ptr_q == LAST) begin
						ws_q <= W_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				default: begin
					ws_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ws_q == W_IDLE && ctl.start) begin
			shift_q <= shift;
			base_q  <= base;
		end
		dst_s1 <= ptr_q;
	end

	// each copy read is written back in the next cycle; source is always above dest
	assign rd_en   = (ws_q == W_COPY);
	assign rd_addr = ptr_q + shift_q;
	assign wr_en   = cpv_s1 || (ws_q == W_FILL);
	assign wr_addr = cpv_s1 ? dst_s1 : ptr_q;
	assign wr_data = cpv_s1 ? rd_data : {8'h00, fill_attr};

	assign sts.busy = (ws_q != W_IDLE);
	assign sts.done = (ws_q == W_FILL) && (ptr_q == LAST);

endmodule
`default_nettype wire

[hdl/tcw_checker.sv]
`default_nettype none
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	localparam int CELLS = ROWS * COLUMNS;

	logic       req_acc;
	logic       rsp_acc;
	logic [2:0] open_q;   // transactions taken on req, not yet delivered on rsp

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			open_q <= open_q + 3'd1;
		end else if (rsp_acc && !req_acc) begin
			open_q <= open_q - 3'd1;
		end
	end

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("req changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 3'd0)
		else $error("rsp without an open request");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd2)
		else $error("more than two transactions in flight");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CELLS > 2048) || (int'(rsp.cursor_position) < CELLS))
		else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
	import tcw_pkg::*;

	localparam int COLS     = 80;
	localparam int ROWS_N   = 25;
	localparam int TAB      = 8;
	localparam int CELLS    = COLS * ROWS_N;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;

	// console shadow state
	logic [7:0] scr_chr [CELLS];
	logic [7:0] scr_att [CELLS];
	int cur_col;
	int cur_row;
	logic [7:0] cur_attr;
	logic [7:0] prev_attr;
	rsp_t console_reports_q [$];

	text_console_writer #(
		.COLUMNS(COLS),
		.ROWS(ROWS_N),
		.TAB_STOP(TAB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ---------------- console model ----------------

	task automatic blank_from(input int first);
		for (int i = first; i < CELLS; i++) begin
			scr_chr[i] = 8'h00;
			scr_att[i] = cur_attr;
		end
	endtask

	task automatic scroll_screen(input int n);
		int shift;
		if (n > ROWS_N)
			n = ROWS_N;
		if (n == 0)
			return;
		shift = n * COLS;
		for (int i = 0; i + shift < CELLS; i++) begin
			scr_chr[i] = scr_chr[i + shift];
			scr_att[i] = scr_att[i + shift];
		end
		blank_from((ROWS_N - n) * COLS);
		cur_row = ROWS_N - n;
		cur_col = 0;
	endtask

	task automatic line_feed();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS_N)
			scroll_screen(1);
	endtask

	task automatic store_glyph(input logic [7:0] ch);
		int a;
		a = cur_col + cur_row * COLS;
		if (a < CELLS) begin
			scr_chr[a] = ch;
			scr_att[a] = cur_attr;
		end
		cur_col++;
		if (cur_col >= COLS)
			line_feed();
	endtask

	task automatic type_char(input logic [7:0] ch);
		case (ch)
			CH_NL: line_feed();
			CH_CR: cur_col = 0;
			CH_BS: begin
				if (cur_col > 0) begin
					cur_col--;
					store_glyph(8'h00);
					cur_col--;
				end
			end
			CH_HT: begin
				cur_col = (cur_col / TAB + 1) * TAB;
				if (cur_col >= COLS)
					line_feed();
			end
			default: store_glyph(ch);
		endcase
	endtask

	task automatic apply_console_op(input req_t r);
		rsp_t e;
		e = '0;
		case (r.op)
			OP_PUT: type_char(r.char_code);
			OP_CLEAR: begin
				blank_from(0);
				cur_col = 0;
				cur_row = 0;
			end
			OP_SET_COLORS: begin
				prev_attr = cur_attr;
				cur_attr = {r.back_color, r.fore_color};
			end
			OP_SET_FORE: begin
				prev_attr = cur_attr;
				cur_attr = (cur_attr & BACK_MASK) | {4'h0, r.fore_color};
			end
			OP_RESTORE: cur_attr = prev_attr;
			OP_SCROLL: scroll_screen(int'(r.scroll_rows));
			OP_READ: begin
				if (r.cell_index < CELLS) begin
					e.cell_char = scr_chr[r.cell_index];
					e.cell_attr = scr_att[r.cell_index];
				end
			end
			default: ;
		endcase
		e.cursor_position = 11'(cur_col + cur_row * COLS);
		e.current_attribute = cur_attr;
		console_reports_q.push_back(e);
	endtask

	// ---------------- result checking ----------------

	task automatic check_field(input string name, input logic [10:0] got,
			input logic [10:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (console_reports_q.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual %p", $time, rsp);
				mismatches++;
			end else begin
				want = console_reports_q.pop_front();
				check_field("cursor_position", rsp.cursor_position, want.cursor_position);
				check_field("cell_char", 11'(rsp.cell_char), 11'(want.cell_char));
				check_field("cell_attr", 11'(rsp.cell_attr), 11'(want.cell_attr));
				check_field("current_attribute", 11'(rsp.current_attribute),
					11'(want.current_attribute));
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic req_t rand_req(input logic [2:0] op);
		req_t r;
		r.op = op;
		r.char_code = 8'($urandom_range(0, 255));
		r.fore_color = 4'($urandom_range(0, 15));
		r.back_color = 4'($urandom_range(0, 15));
		r.scroll_rows = 8'($urandom_range(0, 255));
		r.cell_index = 11'($urandom_range(0, 2047));
		return r;
	endfunction

	task automatic send_req(input req_t item);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		apply_console_op(item);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (console_reports_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_default_attr(input logic [7:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] control_code();
		case ($urandom_range(0, 3))
			0: return CH_BS;
			1: return CH_HT;
			2: return CH_NL;
			default: return CH_CR;
		endcase
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed_ops();
		req_t r;
		r = rand_req(OP_READ);
		r.cell_index = 11'd0;
		send_req(r);
		r.cell_index = 11'(CELLS - 1);
		send_req(r);
		r.cell_index = 11'h7FF;		// past the store
		send_req(r);
		r = rand_req(OP_PUT);
		r.char_code = 8'hFF;
		send_req(r);
		r.char_code = 8'h00;
		send_req(r);
		r.char_code = CH_BS;
		send_req(r);
		r = rand_req(OP_SET_COLORS);
		r.fore_color = 4'hF;
		r.back_color = 4'hF;
		send_req(r);
		r = rand_req(OP_SET_FORE);
		r.fore_color = 4'h0;
		send_req(r);
		send_req(rand_req(OP_RESTORE));
		send_req(rand_req(OP_UNUSED));
		r = rand_req(OP_PUT);
		r.char_code = CH_CR;
		send_req(r);
		r.char_code = CH_BS;		// backspace at column zero
		send_req(r);
		r = rand_req(OP_SCROLL);
		r.scroll_rows = 8'd0;
		send_req(r);
		r.scroll_rows = 8'd255;
		send_req(r);
		r.scroll_rows = 8'd1;		// cursor to last row
		send_req(r);
		r = rand_req(OP_PUT);
		r.char_code = CH_NL;		// newline on last row scrolls
		send_req(r);
		r.char_code = 8'h41;
		send_req(r);
		send_req(rand_req(OP_CLEAR));
		r = rand_req(OP_PUT);
		r.char_code = CH_HT;
		for (int i = 0; i < COLS / TAB; i++)
			send_req(r);
	endtask

	// mostly text with read-back of recently written cells
	task automatic test_text_stream(input int count);
		req_t r;
		int pick;
		int dist_back;
		int pos;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			r = rand_req(OP_PUT);
			if (pick < 50)
				r.char_code = 8'($urandom_range(32, 126));
			else if (pick < 60)
				r.char_code = 8'($urandom_range(0, 255));
			else if (pick < 65)
				r.char_code = CH_NL;
			else if (pick < 68)
				r.char_code = CH_CR;
			else if (pick < 74)
				r.char_code = CH_BS;
			else if (pick < 80)
				r.char_code = CH_HT;
			else if (pick < 95) begin
				r.op = OP_READ;
				dist_back = $urandom_range(0, 2 * COLS);
				pos = cur_col + cur_row * COLS - dist_back;
				r.cell_index = 11'((pos < 0) ? 0 : pos);
			end else begin
				case ($urandom_range(0, 2))
					0: r.op = OP_SET_COLORS;
					1: r.op = OP_SET_FORE;
					default: r.op = OP_RESTORE;
				endcase
			end
			send_req(r);
		end
	endtask

	task automatic test_random_mix(input int count);
		req_t r;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r = rand_req(OP_PUT);
				if ($urandom_range(0, 4) == 0)
					r.char_code = control_code();
			end else if (pick < 48)
				r = rand_req(OP_CLEAR);
			else if (pick < 58)
				r = rand_req(OP_SET_COLORS);
			else if (pick < 68)
				r = rand_req(OP_SET_FORE);
			else if (pick < 76)
				r = rand_req(OP_RESTORE);
			else if (pick < 80) begin
				r = rand_req(OP_SCROLL);
				if ($urandom_range(0, 1) == 0)
					r.scroll_rows = 8'($urandom_range(0, ROWS_N + 5));
			end else if (pick < 95)
				r = rand_req(OP_READ);
			else
				r = rand_req(OP_UNUSED);
			send_req(r);
		end
	endtask

	initial begin
		cur_attr = ATTR_RESET;
		prev_attr = 8'h00;
		cur_col = 0;
		cur_row = 0;
		blank_from(0);
		send_idle_pct = 17;
		recv_idle_pct = 63;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_text_stream(130);
		test_random_mix(100);

		write_default_attr(8'hFF);
		send_idle_pct = 63;
		recv_idle_pct = 17;
		test_text_stream(130);
		test_random_mix(100);

		write_default_attr(8'h00);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_text_stream(130);
		test_random_mix(100);

		write_default_attr(8'($urandom_range(1, 254)));
		drain_results();
		// a full store walk is the longest the block can take
		repeat (CELLS + 16) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
